// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/cbpd_pkg.sv =====
`default_nettype none

package cbpd_pkg;

    localparam int PROB_FRAC_BITS_DEF = 24;
    localparam int NUM_CLASSES        = 5;
    localparam int CHAR_W             = 7;
    localparam int QUAL_W             = 7;
    localparam int QUAL_MAX           = 93;
    localparam int QUAL_RESET         = 70;
    localparam int QUAL_OFFSET        = 33;
    localparam int BIG_W              = 704;

    typedef enum logic [2:0] {
        CLS_GAP,
        CLS_A,
        CLS_C,
        CLS_G,
        CLS_T
    } t_cls;

    function automatic logic [CHAR_W-1:0] class_letter(input t_cls cls);
        logic [CHAR_W-1:0] ch;
        unique case (cls)
            CLS_GAP: ch = 7'd42;
            CLS_A:   ch = 7'd65;
            CLS_C:   ch = 7'd67;
            CLS_G:   ch = 7'd71;
            CLS_T:   ch = 7'd84;
            default: ch = 7'd42;
        endcase
        return ch;
    endfunction

    // Largest residual r with r^10 * 10^k <= 2^(10*frac_bits).
    // Elaboration only: binary search on wide integers.
    function automatic logic [32:0] phred_thr(input int frac_bits, input int k);
        logic [BIG_W-1:0] lim;
        logic [BIG_W-1:0] p10;
        logic [BIG_W-1:0] prod;
        longint           lo;
        longint           hi;
        longint           mid;
        lim = '0;
        lim[10*frac_bits] = 1'b1;
        p10 = BIG_W'(1);
        for (int i = 0; i < k; i++) begin
            p10 = p10 * BIG_W'(10);
        end
        lo = 0;
        hi = longint'(1) << frac_bits;
        while (lo < hi) begin
            mid  = (lo + hi + 1) >> 1;
            prod = p10;
            for (int j = 0; j < 10; j++) begin
                prod = prod * BIG_W'(mid);
            end
            if (prod <= lim) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return 33'(lo);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/consensus_base_and_phred_decode.sv =====
// Throughput: one request per cycle while the output is not stalled; four register stages (input, argmax/residual,
// threshold compare bank, output) each advance independently under backpressure.
// Reset: synchronous, active low; clears all stage valid bits and sets the quality
// cap to 70.
`default_nettype none

`include "assert_macros.svh"

module consensus_base_and_phred_decode #(
    parameter int PROB_FRAC_BITS = cbpd_pkg::PROB_FRAC_BITS_DEF,
    localparam int PW            = PROB_FRAC_BITS + 1,
    localparam int IN_W          = ((cbpd_pkg::NUM_CLASSES * PW + 7) / 8) * 8,
    localparam int OUT_W         = ((2 * cbpd_pkg::CHAR_W + 7) / 8) * 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration: quality_cap
    input  wire logic                        i_cfg_we,
    input  wire logic [cbpd_pkg::QUAL_W-1:0] i_cfg_wdata,
    // slave: prob_gap, prob_a, prob_c, prob_g, prob_t (low to high), zero pad
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [IN_W-1:0]             i_s_tdata,
    // master: base_char, quality_char (low to high), zero pad
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    output logic [OUT_W-1:0]                 o_m_tdata
);

    localparam int QMAX = cbpd_pkg::QUAL_MAX;
    localparam int CW   = cbpd_pkg::CHAR_W;
    localparam int QW   = cbpd_pkg::QUAL_W;
    localparam logic [PW-1:0] ONE = {1'b1, {PROB_FRAC_BITS{1'b0}}};

    logic [QW-1:0] r_cap;
    logic [QW-1:0] cap_eff;

    logic en_s1, en_s2, en_s3, en_out;

    logic          r_s1_valid;
    logic [PW-1:0] r_s1_prob [cbpd_pkg::NUM_CLASSES];

    logic          r_s2_valid;
    cbpd_pkg::t_cls r_s2_idx;
    logic [PW-1:0] r_s2_res;
    cbpd_pkg::t_cls n_s2_idx;
    logic [PW-1:0] n_s2_res;
    logic [PW-1:0] best;

    logic          r_s3_valid;
    cbpd_pkg::t_cls r_s3_idx;
    logic [QMAX:1] r_s3_pass;
    logic [QMAX:1] n_s3_pass;
    logic [QMAX:1] q_top;
    logic [QW-1:0] q_val;

    logic          r_out_valid;
    logic [CW-1:0] r_out_base;
    logic [CW-1:0] r_out_qual;
    logic [CW-1:0] n_out_base;
    logic [CW-1:0] n_out_qual;

    logic          qual_ok;
    logic          base_ok;
    logic          pipe_full;

    // stage enables: a stage loads when empty or when its successor moves
    assign en_out     = !r_out_valid || i_m_tready;
    assign en_s3      = !r_s3_valid || en_out;
    assign en_s2      = !r_s2_valid || en_s3;
    assign en_s1      = !r_s1_valid || en_s2;
    assign o_s_tready = en_s1;

    assign cap_eff = (r_cap > QW'(QMAX)) ? QW'(QMAX) : r_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= QW'(cbpd_pkg::QUAL_RESET);
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_s1) begin
                r_s1_valid <= i_s_tvalid;
            end
            if (en_s2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (en_s3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (en_out) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    // stage 1: input register
    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            for (int i = 0; i < cbpd_pkg::NUM_CLASSES; i++) begin
                r_s1_prob[i] <= i_s_tdata[i*PW +: PW];
            end
        end
    end

    // argmax, lowest index wins a tie; residual saturates at zero
    always_comb begin
        best     = r_s1_prob[0];
        n_s2_idx = cbpd_pkg::CLS_GAP;
        for (int i = 1; i < cbpd_pkg::NUM_CLASSES; i++) begin
            if (r_s1_prob[i] > best) begin
                best     = r_s1_prob[i];
                n_s2_idx = cbpd_pkg::t_cls'(3'(i));
            end
        end
        n_s2_res = (best >= ONE) ? '0 : (ONE - best);
    end

    always_ff @(posedge i_clk) begin
        if (en_s2) begin
            r_s2_idx <= n_s2_idx;
            r_s2_res <= n_s2_res;
        end
    end

    // quality k passes when r <= thr(k); thresholds fall with k, so the
    // pass vector is a thermometer code, clipped at the cap
    for (genvar k = 1; k <= QMAX; k++) begin : g_thr
        localparam logic [PW-1:0] THR = PW'(cbpd_pkg::phred_thr(PROB_FRAC_BITS, k));
        assign n_s3_pass[k] = (r_s2_res <= THR) && (QW'(k) <= cap_eff);
    end

    always_ff @(posedge i_clk) begin
        if (en_s3) begin
            r_s3_idx  <= r_s2_idx;
            r_s3_pass <= n_s3_pass;
        end
    end

    // thermometer to binary via its top set bit
    always_comb begin
        for (int k = 1; k < QMAX; k++) begin
            q_top[k] = r_s3_pass[k] && !r_s3_pass[k+1];
        end
        q_top[QMAX] = r_s3_pass[QMAX];
        q_val = '0;
        for (int k = 1; k <= QMAX; k++) begin
            if (q_top[k]) begin
                q_val = q_val | QW'(k);
            end
        end
        n_out_base = cbpd_pkg::class_letter(r_s3_idx);
        n_out_qual = CW'(cbpd_pkg::QUAL_OFFSET) + CW'(q_val);
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_base <= n_out_base;
            r_out_qual <= n_out_qual;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_W - 2*CW){1'b0}}, r_out_qual, r_out_base};

    assign qual_ok   = (r_out_qual >= CW'(cbpd_pkg::QUAL_OFFSET))
                    && (r_out_qual <= CW'(cbpd_pkg::QUAL_OFFSET + QMAX));
    assign base_ok   = (r_out_base == cbpd_pkg::class_letter(cbpd_pkg::CLS_GAP))
                    || (r_out_base == cbpd_pkg::class_letter(cbpd_pkg::CLS_A))
                    || (r_out_base == cbpd_pkg::class_letter(cbpd_pkg::CLS_C))
                    || (r_out_base == cbpd_pkg::class_letter(cbpd_pkg::CLS_G))
                    || (r_out_base == cbpd_pkg::class_letter(cbpd_pkg::CLS_T));
    assign pipe_full = r_out_valid && r_s3_valid && r_s2_valid && r_s1_valid;

    `ASSERT_IMPL(a_therm_one_top, i_clk, i_rst_n, r_s3_valid, $countones(q_top) <= 1)
    `ASSERT_IMPL(a_qual_range, i_clk, i_rst_n, r_out_valid, qual_ok)
    `ASSERT_IMPL(a_base_legal, i_clk, i_rst_n, r_out_valid, base_ok)
    `ASSERT_IMPL(a_full_stall, i_clk, i_rst_n, pipe_full && !i_m_tready, !o_s_tready)

endmodule

`default_nettype wire

// ===== bench/consensus_call_checker.sv =====
module consensus_call_checker #(
    parameter int FRAC = cbpd_pkg::PROB_FRAC_BITS_DEF,
    parameter int IN_W = ((cbpd_pkg::NUM_CLASSES * (FRAC + 1) + 7) / 8) * 8,
    parameter int OUT_W = ((2 * cbpd_pkg::CHAR_W + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [6:0]       i_cfg_wdata,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    // prob_gap, prob_a, prob_c, prob_g, prob_t (low to high)
    input  logic [IN_W-1:0]  i_s_tdata,
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    // base_char, quality_char (low to high)
    input  logic [OUT_W-1:0] i_m_tdata,
    output int               o_fail_count,
    output int               o_pending
);
    import cbpd_pkg::*;

    localparam int PW       = FRAC + 1;
    // r^10 * 10^93 stays below 2^(10*FRAC + 310)
    localparam int BIG_BITS = 10 * FRAC + 320;
    localparam logic [PW-1:0] ONE = PW'(1) << FRAC;

    typedef struct packed {
        logic [CHAR_W-1:0] base_char;
        logic [CHAR_W-1:0] quality_char;
    } call_t;

    call_t             expected_calls[$];
    logic [QUAL_W-1:0] cap_reg;
    int                mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic logic [CHAR_W-1:0] base_letter(input t_cls cls);
        case (cls)
            CLS_A:   return CHAR_W'("A");
            CLS_C:   return CHAR_W'("C");
            CLS_G:   return CHAR_W'("G");
            CLS_T:   return CHAR_W'("T");
            default: return CHAR_W'("*");
        endcase
    endfunction

    // Largest k <= cap with r^10 * 10^k <= ONE^10, exact in wide integers.
    function automatic int phred_quality(input logic [PW-1:0] p, input logic [QUAL_W-1:0] cap_in);
        logic [BIG_BITS-1:0] acc;
        logic [BIG_BITS-1:0] lim;
        logic [PW-1:0]       resid;
        int                  cap;
        int                  q;
        cap   = (cap_in > QUAL_MAX) ? QUAL_MAX : int'(cap_in);
        resid = (p >= ONE) ? '0 : ONE - p;
        if (resid == '0) begin
            return cap;
        end
        acc = BIG_BITS'(1);
        for (int i = 0; i < 10; i++) begin
            acc = acc * BIG_BITS'(resid);
        end
        lim = '0;
        lim[10*FRAC] = 1'b1;
        q = cap;
        for (int k = 1; k <= cap; k++) begin
            acc = acc * BIG_BITS'(10);
            if (acc > lim) begin
                q = k - 1;
                break;
            end
        end
        return q;
    endfunction

    function automatic call_t predict_call(input logic [IN_W-1:0] data,
                                           input logic [QUAL_W-1:0] cap_in);
        logic [PW-1:0] best;
        logic [PW-1:0] v;
        t_cls          win;
        call_t         c;
        best = data[PW-1:0];
        win  = CLS_GAP;
        for (int i = 1; i < NUM_CLASSES; i++) begin
            v = data[i*PW +: PW];
            if (v > best) begin
                best = v;
                win  = t_cls'(i);
            end
        end
        c.base_char    = base_letter(win);
        c.quality_char = CHAR_W'(QUAL_OFFSET + phred_quality(best, cap_in));
        return c;
    endfunction

    always @(posedge i_clk) begin
        call_t want;
        call_t got;
        if (!i_rst_n) begin
            expected_calls.delete();
            cap_reg = QUAL_W'(QUAL_RESET);
        end else begin
            if (i_cfg_we) begin
                cap_reg = i_cfg_wdata;
            end
            if (i_m_tvalid && i_m_tready) begin
                got.base_char    = i_m_tdata[CHAR_W-1:0];
                got.quality_char = i_m_tdata[2*CHAR_W-1:CHAR_W];
                if (expected_calls.size() == 0) begin
                    $display("%0t unexpected result: base %0d quality %0d", $time,
                             got.base_char, got.quality_char);
                    mismatches++;
                end else begin
                    want = expected_calls.pop_front();
                    if (got.base_char !== want.base_char) begin
                        $display("%0t base_char: expected %0d, actual %0d", $time,
                                 want.base_char, got.base_char);
                        mismatches++;
                    end
                    if (got.quality_char !== want.quality_char) begin
                        $display("%0t quality_char: expected %0d, actual %0d", $time,
                                 want.quality_char, got.quality_char);
                        mismatches++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_calls.push_back(predict_call(i_s_tdata, cap_reg));
            end
        end
        o_pending <= expected_calls.size();
    end

endmodule

// ===== bench/tb_consensus_base_and_phred_decode.sv =====
module tb_consensus_base_and_phred_decode;
    import cbpd_pkg::*;

    localparam int FRAC       = PROB_FRAC_BITS_DEF;
    localparam int PW         = FRAC + 1;
    localparam int IN_W       = ((NUM_CLASSES * PW + 7) / 8) * 8;
    localparam int OUT_W      = ((2 * CHAR_W + 7) / 8) * 8;
    localparam logic [PW-1:0] ONE     = PW'(1) << FRAC;
    localparam logic [PW-1:0] PMAX    = '1;
    localparam int PHASES     = 7;
    localparam int PHASE_LEN  = 140;
    localparam int LONG_HOLD  = 300;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL       = 20;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [QUAL_W-1:0] cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    int                fail_count;
    int                pending;
    bit                hold_go   = 1'b0;
    bit                rx_steady = 1'b0;

    consensus_base_and_phred_decode uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    consensus_call_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [IN_W-1:0] pack_probs(input logic [PW-1:0] gap, input logic [PW-1:0] a,
                                                   input logic [PW-1:0] c, input logic [PW-1:0] g,
                                                   input logic [PW-1:0] t);
        logic [IN_W-1:0] d;
        d = '0;
        d[0*PW +: PW] = gap;
        d[1*PW +: PW] = a;
        d[2*PW +: PW] = c;
        d[3*PW +: PW] = g;
        d[4*PW +: PW] = t;
        return d;
    endfunction

    // Mostly a clear winner with a residual spread over many decades, plus
    // ties, raw noise and winners above one.
    function automatic logic [IN_W-1:0] random_probs();
        logic [PW-1:0] f[NUM_CLASSES];
        logic [PW-1:0] p;
        int            mode;
        int            win;
        int            shift;
        int            resid;
        mode  = $urandom_range(0, 9);
        win   = $urandom_range(0, NUM_CLASSES - 1);
        shift = $urandom_range(0, FRAC);
        resid = $urandom_range(0, 1 << shift);
        p     = ONE - PW'(resid);
        if (mode == 9) begin
            p = PW'($urandom_range(int'(ONE), int'(PMAX)));
        end
        for (int i = 0; i < NUM_CLASSES; i++) begin
            case (mode)
                6:       f[i] = PW'($urandom);
                7:       f[i] = PW'($urandom_range(0, int'(ONE)));
                8:       f[i] = ($urandom_range(0, 1) == 1) ? p : PW'($urandom_range(0, int'(p)));
                default: f[i] = ($urandom_range(0, 7) == 0) ? p : PW'($urandom_range(0, int'(p)));
            endcase
        end
        if (mode != 6 && mode != 7) begin
            f[win] = p;
        end
        return pack_probs(f[0], f[1], f[2], f[3], f[4]);
    endfunction

    task automatic send_probs(input logic [IN_W-1:0] data);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        do @(posedge clk); while (!s_tready);
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_cap(input logic [QUAL_W-1:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // receiver: random ready pattern, one long hold-off on request
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        @(posedge clk);
        forever begin
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (rx_steady) begin
                m_tready <= 1'b1;
                @(posedge clk);
            end else if (gap_len() == 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end else begin
                m_tready <= 1'b0;
                repeat (gap_len() + 1) @(posedge clk);
            end
        end
    end

    // watchdog: cycles with no request moving on either side
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [QUAL_W-1:0] caps[PHASES];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset cap of 70
        send_probs(pack_probs('0, '0, '0, '0, '0));
        send_probs(pack_probs(ONE, '0, '0, '0, '0));
        send_probs(pack_probs('0, ONE, '0, '0, '0));
        send_probs(pack_probs('0, '0, ONE, '0, '0));
        send_probs(pack_probs('0, '0, '0, ONE, '0));
        send_probs(pack_probs('0, '0, '0, '0, ONE));
        send_probs(pack_probs(PMAX, PMAX, PMAX, PMAX, PMAX));
        send_probs(pack_probs(PW'(1), ONE >> 1, ONE >> 1, ONE >> 1, ONE >> 1));
        send_probs(pack_probs('0, '0, '0, '0, ONE - PW'(1)));
        send_probs(pack_probs(PW'(12345), '0, '0, PW'(15099494), PW'(777)));
        send_probs(pack_probs(ONE, PW'(3), PMAX, ONE - PW'(1), PW'(99)));
        send_probs(pack_probs(PMAX, '0, '0, '0, PMAX));

        write_cap(7'd0);
        send_probs(pack_probs('0, '0, '0, '0, ONE));
        send_probs(pack_probs('0, '0, '0, '0, '0));

        write_cap(QUAL_W'(QUAL_MAX));
        send_probs(pack_probs('0, ONE - PW'(1), '0, '0, '0));
        send_probs(pack_probs('0, '0, ONE, '0, '0));

        // caps above the legal range clamp to the maximum
        write_cap(7'd127);
        send_probs(pack_probs('0, '0, '0, ONE, '0));
        send_probs(pack_probs('0, ONE - PW'(1), '0, '0, '0));
        write_cap(QUAL_W'(QUAL_MAX + 1));
        send_probs(pack_probs(ONE, '0, '0, '0, '0));

        write_cap(7'd1);
        send_probs(pack_probs('0, '0, '0, '0, '0));
        send_probs(pack_probs('0, PW'(15938355), '0, '0, '0));

        caps[0] = QUAL_W'(QUAL_MAX);
        caps[1] = QUAL_W'($urandom_range(0, 127));
        caps[2] = 7'd127;
        caps[3] = 7'd20;
        caps[4] = QUAL_W'($urandom_range(0, QUAL_MAX));
        caps[5] = 7'd0;
        caps[6] = QUAL_W'(QUAL_RESET);
        for (int ph = 0; ph < PHASES; ph++) begin
            write_cap(caps[ph]);
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (ph == 1 && n == 40) begin
                    hold_go = 1'b1;
                end
                send_probs(random_probs());
            end
        end

        rx_steady = 1'b1;
        wait_idle();
        repeat (TAIL) @(posedge clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/cbpd_pkg.sv
hdl/consensus_base_and_phred_decode.sv
bench/consensus_call_checker.sv
bench/tb_consensus_base_and_phred_decode.sv
